// ----- src/ttcb_pkg.sv -----
// Shared types and constants for the text terminal cell buffer.
// Used by ttcb_front, ttcb_back and the top level; depends on nothing else.
package ttcb_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 32;

  // Width of internal grid dimensions; wide enough for 256.
  localparam int DIM_W = 9;
  localparam int PRD_W = 2 * DIM_W;

  localparam int KIND_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int COLA_W  = 7;
  localparam int ROWA_W  = 5;
  localparam int LINES_W = 6;
  localparam int MARG_W  = 7;
  localparam int CELL_W  = 16;
  localparam int CCOL_W  = 8;
  localparam int CROW_W  = 5;
  localparam int BRK_W   = 16;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 16;
  localparam int ACOL_W  = 8;
  localparam int AROW_W  = 6;

  // Item kinds.
  localparam logic [KIND_W-1:0] K_PUT    = 3'd0;
  localparam logic [KIND_W-1:0] K_ECHO   = 3'd1;
  localparam logic [KIND_W-1:0] K_SETCUR = 3'd2;
  localparam logic [KIND_W-1:0] K_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] K_SCROLL = 3'd4;
  localparam logic [KIND_W-1:0] K_MARGIN = 3'd5;
  localparam logic [KIND_W-1:0] K_READ   = 3'd6;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_COLS  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_STYLE = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_DEL       = 8'h7f;
  localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_CTRL_LAST = 8'h1a;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CELL_W-1:0] CELL_BLANK     = 16'h0020;

  typedef enum logic [2:0] {
    OP_PUT, OP_ECHO, OP_SETCUR, OP_CLEAR, OP_SCROLL, OP_MARGIN, OP_READ, OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    CH_NONE, CH_DEL, CH_NL, CH_GLYPH
  } chr_e;

  typedef struct packed {
    op_e                 op;
    chr_e                cls;
    logic [CELL_W-1:0]   glyph;
    logic [COLA_W-1:0]   col;
    logic [ROWA_W-1:0]   row;
    logic [LINES_W-1:0]  lines;
    logic [MARG_W-1:0]   lreq;
    logic [MARG_W-1:0]   rreq;
  } cmd_t;

endpackage

// ----- src/ttcb_front.sv -----
// Front end: accepts items, classifies kind and character, and queues commands.
// Depends on ttcb_pkg.
module ttcb_front
  import ttcb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [COLA_W-1:0]   col_arg_i,
  input  logic [ROWA_W-1:0]   row_arg_i,
  input  logic [LINES_W-1:0]  scroll_lines_i,
  input  logic [MARG_W-1:0]   left_request_i,
  input  logic [MARG_W-1:0]   right_request_i,
  input  logic                hold_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new       = '0;
    cmd_new.col   = col_arg_i;
    cmd_new.row   = row_arg_i;
    cmd_new.lines = scroll_lines_i;
    cmd_new.lreq  = left_request_i;
    cmd_new.rreq  = right_request_i;
    unique case (kind_i)
      K_PUT:    cmd_new.op = OP_PUT;
      K_ECHO:   cmd_new.op = OP_ECHO;
      K_SETCUR: cmd_new.op = OP_SETCUR;
      K_CLEAR:  cmd_new.op = OP_CLEAR;
      K_SCROLL: cmd_new.op = OP_SCROLL;
      K_MARGIN: cmd_new.op = OP_MARGIN;
      K_READ:   cmd_new.op = OP_READ;
      default:  cmd_new.op = OP_NOP;
    endcase
    if (char_code_i == CHAR_DEL) begin
      cmd_new.cls = CH_DEL;
    end else if (char_code_i == CHAR_CR || char_code_i == CHAR_LF) begin
      cmd_new.cls = CH_NL;
    end else if (char_code_i > CHAR_CTRL_LAST && char_code_i < CHAR_DEL) begin
      cmd_new.cls   = CH_GLYPH;
      cmd_new.glyph = {8'h00, char_code_i};
    end else if (char_code_i > CHAR_DEL) begin
      cmd_new.cls   = CH_GLYPH;
      cmd_new.glyph = {char_code_i, 8'h00};
    end else begin
      cmd_new.cls = CH_NONE;
    end
  end

  assign in_stall_o  = (count_q == 2'd2) || hold_i;
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (count_q != 2'd0);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/ttcb_back.sv -----
// Back end: executes queued commands against the cell memory and cursor state.
// Holds the configuration registers and the result register. Depends on ttcb_pkg.
module ttcb_back
  import ttcb_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFGI_W-1:0]   cfg_index_i,
  input  logic [CFGD_W-1:0]   cfg_data_i,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                init_busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CELL_W-1:0]   cell_value_o,
  output logic [CHAR_W-1:0]   glyph_o,
  output logic [CCOL_W-1:0]   cursor_col_o,
  output logic [CROW_W-1:0]   cursor_row_o,
  output logic [MARG_W-1:0]   left_margin_now_o,
  output logic [MARG_W-1:0]   right_margin_now_o,
  output logic [BRK_W-1:0]    edit_breaks_o
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_COPY, S_FILL, S_POST, S_GLYPH, S_MARGIN, S_RDATA, S_DONE
  } state_e;

  typedef enum logic [1:0] {POST_HOME, POST_SHIFT, POST_BOTTOM} post_e;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  state_e state_q, state_d;
  post_e  post_q, post_d;
  cmd_t   op_q, op_d;
  logic [ACOL_W-1:0] cols_q, cols_d;
  logic [AROW_W-1:0] rows_q, rows_d;
  logic [CFGD_W-1:0] style_q, style_d;
  logic [CCOL_W-1:0] cur_col_q, cur_col_d;
  logic [CROW_W-1:0] cur_row_q, cur_row_d;
  logic [MARG_W-1:0] lm_q, lm_d, rm_q, rm_d;
  logic [BRK_W-1:0]  brk_q, brk_d;
  logic [NW-1:0]     cnt_q, cnt_d, copy_n_q, copy_n_d, fill_hi_q, fill_hi_d;
  logic [NW-1:0]     src_q, src_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pdst_q, pdst_d;
  logic [LINES_W-1:0] lines_q, lines_d;
  logic              gpend_q, gpend_d;
  logic [DIM_W-1:0]  ml_q, ml_d, mr_q, mr_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic              rdin_q, rdin_d;
  logic              ov_q, ov_d;
  logic [CELL_W-1:0] o_cell_q, o_cell_d;
  logic [CHAR_W-1:0] o_glyph_q, o_glyph_d;
  logic [CCOL_W-1:0] o_col_q, o_col_d;
  logic [CROW_W-1:0] o_row_q, o_row_d;
  logic [MARG_W-1:0] o_lm_q, o_lm_d, o_rm_q, o_rm_d;
  logic [BRK_W-1:0]  o_brk_q, o_brk_d;

  logic [DIM_W-1:0] ncols, nrows, last_row, last_col, cc, cr, rown, sw_lines;
  logic [DIM_W-1:0] tmp9, l9, r9;
  logic             cur_in, nl_req, nl_glyph, sw_req, sw_clear;
  logic [AW-1:0]    cur_addr;
  logic [CHAR_W-1:0] ghi;
  logic [CHAR_W-1:0] gsel;
  logic [MARG_W-1:0] lm_fin;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    ncols = (cols_q == '0) ? DIM_W'(1) :
            ((DIM_W'(cols_q) > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : DIM_W'(cols_q));
    nrows = (rows_q == '0) ? DIM_W'(1) :
            ((DIM_W'(rows_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(rows_q));
    last_row = nrows - DIM_W'(1);
    last_col = ncols - DIM_W'(1);
    cc       = DIM_W'(cur_col_q);
    cr       = DIM_W'(cur_row_q);
    rown     = cr + DIM_W'(1);
    cur_in   = (cc < ncols) && (cr < nrows);
    cur_addr = AW'(PRD_W'(cr * ncols) + PRD_W'(cc));
  end

  always_comb begin
    state_d   = state_q;
    post_d    = post_q;
    op_d      = op_q;
    cols_d    = cols_q;
    rows_d    = rows_q;
    style_d   = style_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    lm_d      = lm_q;
    rm_d      = rm_q;
    brk_d     = brk_q;
    cnt_d     = cnt_q;
    copy_n_d  = copy_n_q;
    fill_hi_d = fill_hi_q;
    src_d     = src_q;
    pend_d    = pend_q;
    pdst_d    = pdst_q;
    lines_d   = lines_q;
    gpend_d   = gpend_q;
    ml_d      = ml_q;
    mr_d      = mr_q;
    cell_d    = cell_q;
    rdin_d    = rdin_q;
    ov_d      = ov_q;
    o_cell_d  = o_cell_q;
    o_glyph_d = o_glyph_q;
    o_col_d   = o_col_q;
    o_row_d   = o_row_q;
    o_lm_d    = o_lm_q;
    o_rm_d    = o_rm_q;
    o_brk_d   = o_brk_q;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    mem_raddr = AW'(src_q + cnt_q);
    cmd_pop_o = 1'b0;
    nl_req    = 1'b0;
    nl_glyph  = 1'b0;
    sw_req    = 1'b0;
    sw_clear  = 1'b0;
    sw_lines  = DIM_W'(1);
    tmp9      = '0;
    l9        = '0;
    r9        = '0;
    ghi       = '0;
    gsel      = '0;
    lm_fin    = lm_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLS:  cols_d  = cfg_data_i[ACOL_W-1:0];
        CFG_ROWS:  rows_d  = cfg_data_i[AROW_W-1:0];
        CFG_STYLE: style_d = cfg_data_i;
        default:   ;
      endcase
    end

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = CELL_BLANK;
        cnt_d     = cnt_q + NW'(1);
        if (cnt_q == NW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        cell_d  = '0;
        state_d = S_DONE;
        unique case (op_q.op) inside
          OP_PUT, OP_ECHO: begin
            unique case (op_q.cls)
              CH_DEL: begin
                if (cur_in) begin
                  mem_we    = 1'b1;
                  mem_wdata = '0;
                end
                if (cc <= DIM_W'(lm_q)) begin
                  cur_col_d = CCOL_W'(last_col);
                  if (cur_row_q != '0) cur_row_d = cur_row_q - CROW_W'(1);
                end else begin
                  cur_col_d = cur_col_q - CCOL_W'(1);
                end
              end
              CH_NL: nl_req = 1'b1;
              CH_GLYPH: begin
                if (cc >= ncols) begin
                  nl_req   = 1'b1;
                  nl_glyph = 1'b1;
                end else begin
                  state_d = S_GLYPH;
                end
              end
              default: ;
            endcase
          end
          OP_SETCUR: begin
            brk_d = brk_q + BRK_W'(1);
            tmp9  = DIM_W'(lm_q) + DIM_W'(op_q.col);
            if (tmp9 > last_col) tmp9 = last_col;
            cur_col_d = CCOL_W'(tmp9);
            r9 = DIM_W'(op_q.row);
            if (r9 > last_row) r9 = last_row;
            cur_row_d = CROW_W'(r9);
          end
          OP_CLEAR: begin
            brk_d    = brk_q + BRK_W'(1);
            sw_req   = 1'b1;
            sw_clear = 1'b1;
            post_d   = POST_HOME;
          end
          OP_SCROLL: begin
            brk_d   = brk_q + BRK_W'(1);
            lines_d = op_q.lines;
            if (op_q.lines != '0) begin
              sw_req = 1'b1;
              if (DIM_W'(op_q.lines) >= nrows) begin
                brk_d    = brk_q + BRK_W'(2);
                sw_clear = 1'b1;
                post_d   = POST_HOME;
              end else begin
                sw_lines = DIM_W'(op_q.lines);
                post_d   = POST_SHIFT;
              end
            end
          end
          OP_MARGIN: begin
            l9      = DIM_W'(op_q.lreq);
            r9      = DIM_W'(op_q.rreq);
            ml_d    = (l9 > last_col) ? last_col : l9;
            mr_d    = (r9 > last_col) ? last_col : r9;
            state_d = S_MARGIN;
          end
          OP_READ: begin
            mem_raddr = AW'(PRD_W'(DIM_W'(op_q.row) * ncols) + PRD_W'(op_q.col));
            rdin_d    = (DIM_W'(op_q.col) < ncols) && (DIM_W'(op_q.row) < nrows);
            state_d   = S_RDATA;
          end
          default: ;
        endcase

        // Newline: move to the left margin of the next row, scrolling near the bottom.
        if (nl_req) begin
          cur_col_d = CCOL_W'(lm_q);
          gpend_d   = nl_glyph;
          if (rown >= last_row) begin
            brk_d  = brk_q + BRK_W'(1);
            sw_req = 1'b1;
            post_d = POST_BOTTOM;
            if (nrows == DIM_W'(1)) begin
              brk_d    = brk_q + BRK_W'(2);
              sw_clear = 1'b1;
            end
          end else begin
            cur_row_d = CROW_W'(rown);
            state_d   = nl_glyph ? S_GLYPH : S_DONE;
          end
        end else begin
          gpend_d = 1'b0;
        end

        // Start a copy-then-fill sweep; a clear is a sweep with nothing to copy.
        if (sw_req) begin
          cnt_d     = '0;
          pend_d    = 1'b0;
          fill_hi_d = NW'(nrows * ncols);
          if (sw_clear) begin
            copy_n_d = '0;
            src_d    = '0;
          end else begin
            copy_n_d = NW'((nrows - sw_lines) * ncols);
            src_d    = NW'(sw_lines * ncols);
          end
          state_d = S_COPY;
        end
      end
      S_COPY: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pdst_q;
          mem_wdata = rdata_q;
        end
        if (cnt_q < copy_n_q) begin
          pend_d = 1'b1;
          pdst_d = AW'(cnt_q);
          cnt_d  = cnt_q + NW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (cnt_q < fill_hi_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_q);
          mem_wdata = style_q | CELL_BLANK;
          cnt_d     = cnt_q + NW'(1);
        end else begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        unique case (post_q)
          POST_HOME: begin
            cur_row_d = '0;
            cur_col_d = CCOL_W'(lm_q);
          end
          POST_SHIFT: begin
            tmp9 = (cr >= DIM_W'(lines_q)) ? cr - DIM_W'(lines_q) : '0;
            if (tmp9 > last_row) tmp9 = last_row;
            cur_row_d = CROW_W'(tmp9);
          end
          POST_BOTTOM: cur_row_d = CROW_W'(last_row);
          default: ;
        endcase
        state_d = gpend_q ? S_GLYPH : S_DONE;
      end
      S_GLYPH: begin
        if (cur_in) begin
          mem_we    = 1'b1;
          mem_wdata = op_q.glyph | style_q;
        end
        cur_col_d = cur_col_q + CCOL_W'(1);
        state_d   = S_DONE;
      end
      S_MARGIN: begin
        if ((DIM_W+1)'(ml_q) + (DIM_W+1)'(mr_q) + (DIM_W+1)'(2) < (DIM_W+1)'(ncols)) begin
          lm_d    = MARG_W'(ml_q);
          rm_d    = MARG_W'(mr_q);
          state_d = S_DONE;
        end else if (ml_q == '0 && mr_q == '0) begin
          lm_d    = '0;
          rm_d    = '0;
          state_d = S_DONE;
        end else begin
          ml_d = (ml_q == '0) ? '0 : ml_q - DIM_W'(1);
          mr_d = (mr_q == '0) ? '0 : mr_q - DIM_W'(1);
        end
      end
      S_RDATA: begin
        if (rdin_q) cell_d = rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          if (op_q.op == OP_ECHO) lm_fin = '0;
          lm_d = lm_fin;
          ghi  = cell_q[15:8];
          gsel = (ghi != '0) ? ghi : {1'b0, cell_q[6:0]};
          if (gsel < CHAR_SPACE) gsel = CHAR_SPACE;
          ov_d      = 1'b1;
          o_cell_d  = cell_q;
          o_glyph_d = gsel;
          o_col_d   = cur_col_q;
          o_row_d   = cur_row_q;
          o_lm_d    = lm_fin;
          o_rm_d    = rm_q;
          o_brk_d   = brk_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      post_q    <= POST_HOME;
      op_q      <= '0;
      cols_q    <= ACOL_W'(80);
      rows_q    <= AROW_W'(25);
      style_q   <= '0;
      cur_col_q <= '0;
      cur_row_q <= '0;
      lm_q      <= '0;
      rm_q      <= '0;
      brk_q     <= '0;
      cnt_q     <= '0;
      copy_n_q  <= '0;
      fill_hi_q <= '0;
      src_q     <= '0;
      pend_q    <= 1'b0;
      pdst_q    <= '0;
      lines_q   <= '0;
      gpend_q   <= 1'b0;
      ml_q      <= '0;
      mr_q      <= '0;
      cell_q    <= '0;
      rdin_q    <= 1'b0;
      ov_q      <= 1'b0;
      o_cell_q  <= '0;
      o_glyph_q <= '0;
      o_col_q   <= '0;
      o_row_q   <= '0;
      o_lm_q    <= '0;
      o_rm_q    <= '0;
      o_brk_q   <= '0;
    end else begin
      state_q   <= state_d;
      post_q    <= post_d;
      op_q      <= op_d;
      cols_q    <= cols_d;
      rows_q    <= rows_d;
      style_q   <= style_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      lm_q      <= lm_d;
      rm_q      <= rm_d;
      brk_q     <= brk_d;
      cnt_q     <= cnt_d;
      copy_n_q  <= copy_n_d;
      fill_hi_q <= fill_hi_d;
      src_q     <= src_d;
      pend_q    <= pend_d;
      pdst_q    <= pdst_d;
      lines_q   <= lines_d;
      gpend_q   <= gpend_d;
      ml_q      <= ml_d;
      mr_q      <= mr_d;
      cell_q    <= cell_d;
      rdin_q    <= rdin_d;
      ov_q      <= ov_d;
      o_cell_q  <= o_cell_d;
      o_glyph_q <= o_glyph_d;
      o_col_q   <= o_col_d;
      o_row_q   <= o_row_d;
      o_lm_q    <= o_lm_d;
      o_rm_q    <= o_rm_d;
      o_brk_q   <= o_brk_d;
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign init_busy_o        = (state_q == S_INIT);
  assign out_valid_o        = ov_q;
  assign cell_value_o       = o_cell_q;
  assign glyph_o            = o_glyph_q;
  assign cursor_col_o       = o_col_q;
  assign cursor_row_o       = o_row_q;
  assign left_margin_now_o  = o_lm_q;
  assign right_margin_now_o = o_rm_q;
  assign edit_breaks_o      = o_brk_q;

endmodule

// ----- src/text_terminal_cell_buffer_top.sv -----
// Top level of the text terminal cell buffer.
// Instantiates ttcb_front and ttcb_back; depends on ttcb_pkg.

// The block keeps a grid of 16-bit cells with a cursor, left and right margins and an
// edit-break counter, and returns one result item for every input item. After reset it
// first walks the whole cell memory, one entry per cycle, writing blanks; input stays
// stalled during that pass while configuration writes are taken at any time. A front
// end decodes items into a two-entry command queue, so up to two items can be taken
// while the back end works or while a result waits to be taken. The back end runs one
// command at a time over the cell memory, which has one write port and one read port; a
// glyph write adds the S_GLYPH state, a read the S_RDATA state, and setting margins
// shrinks both requests step by step until they fit. Clear fills rows * columns cells at
// one per cycle; a scroll copies the kept cells and blanks the freed rows at one cell per
// cycle, and a newline that reaches the bottom row scrolls as well.
module text_terminal_cell_buffer_top
  import ttcb_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [COLA_W-1:0]   col_arg_i,
  input  logic [ROWA_W-1:0]   row_arg_i,
  input  logic [LINES_W-1:0]  scroll_lines_i,
  input  logic [MARG_W-1:0]   left_request_i,
  input  logic [MARG_W-1:0]   right_request_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CELL_W-1:0]   cell_value_o,
  output logic [CHAR_W-1:0]   glyph_o,
  output logic [CCOL_W-1:0]   cursor_col_o,
  output logic [CROW_W-1:0]   cursor_row_o,
  output logic [MARG_W-1:0]   left_margin_now_o,
  output logic [MARG_W-1:0]   right_margin_now_o,
  output logic [BRK_W-1:0]    edit_breaks_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFGI_W-1:0]   cfg_index_i,
  input  logic [CFGD_W-1:0]   cfg_data_i
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop, init_busy;

  // Item intake and classification; held off while the reset pass runs.
  ttcb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .col_arg_i       (col_arg_i),
    .row_arg_i       (row_arg_i),
    .scroll_lines_i  (scroll_lines_i),
    .left_request_i  (left_request_i),
    .right_request_i (right_request_i),
    .hold_i          (init_busy),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Command execution, cell memory, configuration and the result register.
  ttcb_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_valid_i        (cmd_valid),
    .cmd_i              (cmd),
    .cmd_pop_o          (cmd_pop),
    .init_busy_o        (init_busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cell_value_o       (cell_value_o),
    .glyph_o            (glyph_o),
    .cursor_col_o       (cursor_col_o),
    .cursor_row_o       (cursor_row_o),
    .left_margin_now_o  (left_margin_now_o),
    .right_margin_now_o (right_margin_now_o),
    .edit_breaks_o      (edit_breaks_o)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for text_terminal_cell_buffer_top.
// Holds its own screen predictor, a queued driver and a monitor; depends on ttcb_pkg and the RTL.
module tb_top;
  import ttcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A stalled cycle can last a whole clear or scroll of the largest grid (4096 cells,
  // copy plus blank) or the clearing pass after reset, so the limit leaves a wide margin.
  localparam int IDLE_LIMIT = 40000;
  localparam int GRID_CELLS = MAX_COLUMNS_DEF * MAX_ROWS_DEF;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  code;
    logic [COLA_W-1:0]  col;
    logic [ROWA_W-1:0]  row;
    logic [LINES_W-1:0] lines;
    logic [MARG_W-1:0]  lreq;
    logic [MARG_W-1:0]  rreq;
  } term_item_t;

  typedef struct {
    logic [CELL_W-1:0] cell_word;
    logic [CHAR_W-1:0] glyph;
    logic [CCOL_W-1:0] ccol;
    logic [CROW_W-1:0] crow;
    logic [MARG_W-1:0] lm;
    logic [MARG_W-1:0] rm;
    logic [BRK_W-1:0]  brk;
  } screen_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  kind = '0;
  logic [CHAR_W-1:0]  char_code = '0;
  logic [COLA_W-1:0]  col_arg = '0;
  logic [ROWA_W-1:0]  row_arg = '0;
  logic [LINES_W-1:0] scroll_lines = '0;
  logic [MARG_W-1:0]  left_req = '0;
  logic [MARG_W-1:0]  right_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CELL_W-1:0]  cell_value;
  logic [CHAR_W-1:0]  glyph;
  logic [CCOL_W-1:0]  cursor_col;
  logic [CROW_W-1:0]  cursor_row;
  logic [MARG_W-1:0]  left_now;
  logic [MARG_W-1:0]  right_now;
  logic [BRK_W-1:0]   edit_breaks;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFGI_W-1:0]  cfg_index = '0;
  logic [CFGD_W-1:0]  cfg_data = '0;

  text_terminal_cell_buffer_top u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .kind_i             (kind),
    .char_code_i        (char_code),
    .col_arg_i          (col_arg),
    .row_arg_i          (row_arg),
    .scroll_lines_i     (scroll_lines),
    .left_request_i     (left_req),
    .right_request_i    (right_req),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .cell_value_o       (cell_value),
    .glyph_o            (glyph),
    .cursor_col_o       (cursor_col),
    .cursor_row_o       (cursor_row),
    .left_margin_now_o  (left_now),
    .right_margin_now_o (right_now),
    .edit_breaks_o      (edit_breaks),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Screen predictor: its own copy of the cells, cursor, margins, break count
  // and the three configuration registers as last written.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] scr_cells [GRID_CELLS];
  int                scr_col, scr_row, scr_lm, scr_rm;
  logic [BRK_W-1:0]  scr_breaks;
  int                reg_cols = 80;
  int                reg_rows = 25;
  logic [CFGD_W-1:0] reg_style = '0;

  function automatic int grid_cols();
    return (reg_cols < 1) ? 1 : (reg_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : reg_cols;
  endfunction

  function automatic int grid_rows();
    return (reg_rows < 1) ? 1 : (reg_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : reg_rows;
  endfunction

  function automatic bit on_grid(int c, int r);
    return c < grid_cols() && r < grid_rows();
  endfunction

  function automatic void blank_rows(int from, int upto);
    for (int r = from; r < upto && r < grid_rows(); r++) begin
      for (int c = 0; c < grid_cols(); c++)
        scr_cells[r * grid_cols() + c] = reg_style | CELL_BLANK;
    end
  endfunction

  function automatic void screen_clear();
    scr_breaks++;
    blank_rows(0, grid_rows());
    scr_row = 0;
    scr_col = scr_lm;
  endfunction

  function automatic void screen_scroll(int lines);
    int rows;
    int cols;
    rows = grid_rows();
    cols = grid_cols();
    scr_breaks++;
    if (lines == 0) return;
    if (lines >= rows) begin
      screen_clear();
      return;
    end
    // Source lies ahead of destination, so a forward copy is safe.
    for (int i = 0; i < (rows - lines) * cols; i++) scr_cells[i] = scr_cells[i + lines * cols];
    blank_rows(rows - lines, rows);
    scr_row = (scr_row >= lines) ? scr_row - lines : 0;
    if (scr_row > rows - 1) scr_row = rows - 1;
  endfunction

  function automatic void new_line();
    scr_row++;
    scr_col = scr_lm;
    if (scr_row >= grid_rows() - 1) begin
      screen_scroll(1);
      scr_row = grid_rows() - 1;
    end
  endfunction

  function automatic void place_glyph(logic [CELL_W-1:0] v);
    if (scr_col >= grid_cols()) new_line();
    if (on_grid(scr_col, scr_row)) scr_cells[scr_row * grid_cols() + scr_col] = v | reg_style;
    scr_col++;
  endfunction

  function automatic void type_char(logic [CHAR_W-1:0] code);
    if (code == CHAR_DEL) begin
      if (on_grid(scr_col, scr_row)) scr_cells[scr_row * grid_cols() + scr_col] = '0;
      if (scr_col <= scr_lm) begin
        scr_col = grid_cols() - 1;
        if (scr_row > 0) scr_row--;
      end else begin
        scr_col--;
      end
    end else if (code == CHAR_CR || code == CHAR_LF) begin
      new_line();
    end else if (code > CHAR_CTRL_LAST && code < CHAR_DEL) begin
      place_glyph({8'h00, code});
    end else if (code > CHAR_DEL) begin
      place_glyph({code, 8'h00});
    end
  endfunction

  // Applies one accepted item to the screen and returns what the block must report.
  function automatic screen_view_t screen_apply(term_item_t it);
    screen_view_t v;
    logic [CELL_W-1:0] cell_word;
    int l, r, cl, cr, mx;
    cell_word = '0;
    case (it.kind)
      K_PUT:  type_char(it.code);
      K_ECHO: begin
        type_char(it.code);
        scr_lm = 0;
      end
      K_SETCUR: begin
        scr_breaks++;
        scr_col = scr_lm + int'(it.col);
        scr_row = int'(it.row);
        if (scr_col > grid_cols() - 1) scr_col = grid_cols() - 1;
        if (scr_row > grid_rows() - 1) scr_row = grid_rows() - 1;
      end
      K_CLEAR:  screen_clear();
      K_SCROLL: screen_scroll(int'(it.lines));
      K_MARGIN: begin
        // Clamp both requests into the row, then shrink both until they fit.
        mx = grid_cols() - 1;
        l = int'(it.lreq);
        r = int'(it.rreq);
        forever begin
          cl = (l <= mx) ? ((l < 0) ? 0 : l) : mx;
          cr = (r <= mx) ? ((r < 0) ? 0 : r) : mx;
          if (cl + cr < grid_cols() - 2 || (cl == 0 && cr == 0)) begin
            scr_lm = cl;
            scr_rm = cr;
            break;
          end
          l = cl - 1;
          r = cr - 1;
        end
      end
      K_READ: begin
        if (on_grid(int'(it.col), int'(it.row)))
          cell_word = scr_cells[int'(it.row) * grid_cols() + int'(it.col)];
      end
      default: ;
    endcase
    v.cell_word = cell_word;
    v.glyph = (cell_word[15:8] != 0) ? cell_word[15:8] : {1'b0, cell_word[6:0]};
    if (v.glyph < CHAR_SPACE) v.glyph = CHAR_SPACE;
    v.ccol = scr_col[CCOL_W-1:0];
    v.crow = scr_row[CROW_W-1:0];
    v.lm   = scr_lm[MARG_W-1:0];
    v.rm   = scr_rm[MARG_W-1:0];
    v.brk  = scr_breaks;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pulls from the pending queue in bursts of random length with random
  // gaps in between. A stalled item is held unchanged.
  // ---------------------------------------------------------------------------
  term_item_t   pending_items [$];
  screen_view_t expected_views [$];
  int burst_left = 0;
  int gap_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_phase = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (in_valid && in_stall) begin
      // Hold the current item until it is taken.
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      term_item_t it;
      it = pending_items.pop_front();
      in_valid     <= 1'b1;
      kind         <= it.kind;
      char_code    <= it.code;
      col_arg      <= it.col;
      row_arg      <= it.row;
      scroll_lines <= it.lines;
      left_req     <= it.lreq;
      right_req    <= it.rreq;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall: a mode picked at random whenever stall_phase is a multiple of 64 (never, light, heavy stalling).
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input item and checks every accepted
  // result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      term_item_t it;
      it = '{kind, char_code, col_arg, row_arg, scroll_lines, left_req, right_req};
      expected_views.push_back(screen_apply(it));
    end
    if (out_valid && !out_stall) begin
      screen_view_t want;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with no expectation waiting");
      end else begin
        want = expected_views.pop_front();
        if (want.cell_word != cell_value || want.glyph != glyph || want.ccol != cursor_col ||
            want.crow != cursor_row || want.lm != left_now || want.rm != right_now ||
            want.brk != edit_breaks) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp cell=%h gl=%h cur=%0d,%0d lm=%0d rm=%0d brk=%0d",
                      " / got cell=%h gl=%h cur=%0d,%0d lm=%0d rm=%0d brk=%0d"},
                     want.cell_word, want.glyph, want.ccol, want.crow, want.lm, want.rm,
                     want.brk, cell_value, glyph, cursor_col, cursor_row, left_now,
                     right_now, edit_breaks);
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL text_terminal_cell_buffer_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Builds an item of the given kind; every field the caller leaves open (-1 or x) gets random content.
  function automatic term_item_t make_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] code,
                                           int c, int r, int lines, int lq, int rq);
    term_item_t it;
    it.kind  = k;
    it.code  = (code === 'x) ? CHAR_W'($urandom_range(0, 255)) : code;
    it.col   = COLA_W'((c < 0) ? $urandom_range(0, 127) : c);
    it.row   = ROWA_W'((r < 0) ? $urandom_range(0, 31) : r);
    it.lines = LINES_W'((lines < 0) ? $urandom_range(0, 32) : lines);
    it.lreq  = MARG_W'((lq < 0) ? $urandom_range(0, 127) : lq);
    it.rreq  = MARG_W'((rq < 0) ? $urandom_range(0, 127) : rq);
    return it;
  endfunction

  // Mostly text: printable runs, line breaks, deletes and control codes, with echoes, cursor
  // moves, reads, margin changes and the occasional screen-wide operation or no-op mixed in.
  function automatic term_item_t text_item();
    int pick;
    int cols;
    int rows;
    pick = $urandom_range(0, 99);
    cols = grid_cols();
    rows = grid_rows();
    if (pick < 40)
      return make_item(K_PUT, CHAR_W'($urandom_range(8'h1b, 8'h7e)), -1, -1, -1, -1, -1);
    if (pick < 48)
      return make_item(K_PUT, CHAR_W'($urandom_range(8'h80, 8'hff)), -1, -1, -1, -1, -1);
    if (pick < 55)
      return make_item(K_PUT, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF, -1, -1, -1, -1, -1);
    if (pick < 62) return make_item(K_PUT, CHAR_DEL, -1, -1, -1, -1, -1);
    if (pick < 64)
      return make_item(K_PUT, CHAR_W'($urandom_range(0, 8'h1a)), -1, -1, -1, -1, -1);
    if (pick < 69) return make_item(K_ECHO, 'x, -1, -1, -1, -1, -1);
    if (pick < 75)
      return make_item(K_SETCUR, 'x, $urandom_range(0, cols), $urandom_range(0, rows),
                       -1, -1, -1);
    if (pick < 88) begin
      if ($urandom_range(0, 9) == 0) return make_item(K_READ, 'x, -1, -1, -1, -1, -1);
      return make_item(K_READ, 'x, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                       -1, -1, -1);
    end
    if (pick < 91) return make_item(K_CLEAR, 'x, -1, -1, -1, -1, -1);
    if (pick < 94)
      return make_item(K_SCROLL, 'x, -1, -1,
                       $urandom_range(0, 3) ? $urandom_range(0, rows + 1) : -1, -1, -1);
    if (pick < 98) begin
      if ($urandom_range(0, 1)) return make_item(K_MARGIN, 'x, -1, -1, -1, -1, -1);
      return make_item(K_MARGIN, 'x, -1, -1, -1, $urandom_range(0, cols), $urandom_range(0, cols));
    end
    return make_item(OP_NOP, 'x, -1, -1, -1, -1, -1);
  endfunction

  // Waits until everything queued has been taken and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_views.size() > 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLS:  reg_cols = int'(data[ACOL_W-1:0]);
      CFG_ROWS:  reg_rows = int'(data[AROW_W-1:0]);
      CFG_STYLE: reg_style = data;
      default: ;
    endcase
  endtask

  // One phase: new grid and style while idle, a clear to settle the grid, then text.
  task automatic text_phase(int cols, int rows, logic [CFGD_W-1:0] style, int count);
    wait_drained();
    write_reg(CFG_COLS, CFGD_W'(cols));
    write_reg(CFG_ROWS, CFGD_W'(rows));
    write_reg(CFG_STYLE, style);
    @(posedge clk);
    pending_items.push_back(make_item(K_CLEAR, 'x, -1, -1, -1, -1, -1));
    for (int i = 1; i < count; i++) pending_items.push_back(text_item());
  endtask

  initial begin
    scr_col = 0;
    scr_row = 0;
    scr_lm = 0;
    scr_rm = 0;
    scr_breaks = '0;
    foreach (scr_cells[i]) scr_cells[i] = CELL_BLANK;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset grid of 80 by 25.
    pending_items.push_back(make_item(K_READ, 'x, 0, 0, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h41, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h1b, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h7e, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h80, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'hff, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h00, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, CHAR_CTRL_LAST, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_READ, 'x, 3, 0, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, CHAR_CR, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, CHAR_LF, -1, -1, -1, -1, -1));
    // Delete at the left margin walks back up to the end of the row above.
    pending_items.push_back(make_item(K_PUT, CHAR_DEL, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_READ, 'x, 127, 31, -1, -1, -1));
    // Cursor clamped to the corner, then autowrap from the last column.
    pending_items.push_back(make_item(K_SETCUR, 'x, 127, 31, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h5a, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_PUT, 8'h5b, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_MARGIN, 'x, -1, -1, -1, 127, 127));
    pending_items.push_back(make_item(K_MARGIN, 'x, -1, -1, -1, 10, 5));
    pending_items.push_back(make_item(K_ECHO, 8'h61, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_SCROLL, 'x, -1, -1, 0, -1, -1));
    pending_items.push_back(make_item(K_SCROLL, 'x, -1, -1, 1, -1, -1));
    pending_items.push_back(make_item(K_SCROLL, 'x, -1, -1, 32, -1, -1));
    pending_items.push_back(make_item(K_CLEAR, 'x, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(OP_NOP, 'x, -1, -1, -1, -1, -1));
    pending_items.push_back(make_item(K_MARGIN, 'x, -1, -1, -1, 0, 0));

    // Random part: extremes of the registers first, then mostly small grids so that
    // clears and scrolls stay cheap.
    text_phase(1, 1, 16'hffff, 30);
    text_phase(0, 0, 16'h0000, 20);
    text_phase(3, 2, 16'h5a00, 40);
    text_phase(128, 32, 16'h0000, 25);
    text_phase(255, 63, 16'h8001, 12);
    for (int p = 0; p < 12; p++)
      text_phase($urandom_range(3, 16), $urandom_range(2, 8),
                 CFGD_W'($urandom_range(0, 16'hffff)), 55);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS text_terminal_cell_buffer_top");
    end else begin
      $display("FAIL text_terminal_cell_buffer_top");
    end
    $finish;
  end

endmodule
